### design/svalloc_pkg.sv
// Shared types and constants for the voice allocator.
// Used by every module of the block; no dependencies.
package svalloc_pkg;

    localparam int NUM_VOICES = 8;
    localparam int HELD_DEPTH = 16;

    localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int HELD_AW = $clog2(HELD_DEPTH);
    localparam int HCNT_W = $clog2(HELD_DEPTH + 1);

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW = $clog2(CMDQ_DEPTH + 1);

    localparam logic [1:0] REQ_NOTE_ON = 2'd0;
    localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
    localparam logic [1:0] REQ_VOICE_DONE = 2'd2;

    localparam logic [1:0] CMD_ON = 2'd0;
    localparam logic [1:0] CMD_OFF = 2'd1;
    localparam logic [1:0] CMD_FIN = 2'd2;

    localparam logic ACT_RELEASE = 1'b0;
    localparam logic ACT_START = 1'b1;

    localparam logic [6:0] RETRIG_VELOCITY = 7'd102;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] note;
        logic [6:0] velocity;
        logic [2:0] voice_id;
    } cmd_t;

    typedef struct packed {
        logic       action;
        logic [2:0] voice_index;
        logic [6:0] start_note;
        logic [6:0] start_velocity;
        logic       was_stolen;
        logic       glide;
        logic [6:0] glide_from_note;
        logic       last_of_run;
    } res_t;

    typedef struct packed {
        logic mono_mode;
        logic glide_enable;
    } cfg_t;

endpackage

### design/svalloc_if.sv
// Valid/ready channel interfaces for request and result transfers.
// Depends on nothing; payload widths follow the block's field list.
interface svalloc_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [6:0] note;
    logic [6:0] velocity;
    logic [2:0] voice_id;

    modport source (output valid, output req_type, output note, output velocity,
                    output voice_id, input ready);
    modport sink (input valid, input req_type, input note, input velocity,
                  input voice_id, output ready);
endinterface

interface svalloc_res_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [2:0] voice_index;
    logic [6:0] start_note;
    logic [6:0] start_velocity;
    logic       was_stolen;
    logic       glide;
    logic [6:0] glide_from_note;
    logic       last_of_run;

    modport source (output valid, output action, output voice_index, output start_note,
                    output start_velocity, output was_stolen, output glide,
                    output glide_from_note, output last_of_run, input ready);
    modport sink (input valid, input action, input voice_index, input start_note,
                  input start_velocity, input was_stolen, input glide,
                  input glide_from_note, input last_of_run, output ready);
endinterface

### design/synth_voice_allocator.sv
// Voice allocator top level: APB register block, front end, queue, sequencer.
// Depends on svalloc_pkg, svalloc_if, svalloc_front, svalloc_cmd_fifo, svalloc_back.
//
// Usage: requests (note on, note off, voice finished) arrive as transfers on req;
// each causes a run of zero or more result transfers on res, the final one
// flagged by last_of_run. A four-entry command queue parts intake from
// execution, so req keeps accepting while res is stalled until the queue fills.
// With res ready, a voice-finished request gives no result and clears its voice
// when the sequencer takes it from the queue; a polyphonic note on that finds no
// free voice runs an oldest-voice search that visits one voice per cycle.
// Releases go out one per cycle on the result register while res is ready; the
// held-stack sweep through its single memory port runs on a mono note off or a
// push onto a full stack, and a mono note off with retrigger runs the sweep, the
// releases and a start. The sequencer runs one request at a time.
// Registers: mono_mode at byte 0, glide_enable at byte 4, bit 0; write only
// while idle. Reset (rst_n low) clears all voices, the stack count, the
// stamp counter and the last-note record; stack contents stay undefined.
// A stalled res holds its result; the sequencer waits only when it has another result to give.
module synth_voice_allocator
    import svalloc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    svalloc_req_if.sink req,
    svalloc_res_if.source res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic mono_reg, mono_next;
    logic glide_reg, glide_next;
    cfg_t cfg;
    logic q_full, q_push, q_pop, q_empty;
    cmd_t q_in, q_out;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {31'b0, glide_reg} : {31'b0, mono_reg};

    always_comb
    begin
        mono_next = mono_reg;
        glide_next = glide_reg;
        if (psel && penable && pwrite)
        begin
            if (paddr[2])
            begin
                glide_next = pwdata[0];
            end
            else
            begin
                mono_next = pwdata[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_reg <= 1'b0;
            glide_reg <= 1'b0;
        end
        else
        begin
            mono_reg <= mono_next;
            glide_reg <= glide_next;
        end
    end

    assign cfg.mono_mode = mono_reg;
    assign cfg.glide_enable = glide_reg;

    svalloc_front u_front (
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    svalloc_cmd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    svalloc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .res     (res)
    );

endmodule

### design/svalloc_front.sv
// Front end: accepts request transfers, classifies them into commands.
// Depends on svalloc_pkg and svalloc_req_if; feeds svalloc_cmd_fifo.
module svalloc_front
    import svalloc_pkg::*;
(
    svalloc_req_if.sink req,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_data
);

    logic accept;

    assign req.ready = !q_full;
    assign accept = req.valid && !q_full;

    always_comb
    begin
        q_push = 1'b0;
        q_data.kind = CMD_ON;
        q_data.note = req.note;
        q_data.velocity = req.velocity;
        q_data.voice_id = req.voice_id;
        case (req.req_type)
            REQ_NOTE_ON:
            begin
                q_data.kind = CMD_ON;
                q_push = accept;
            end
            REQ_NOTE_OFF:
            begin
                q_data.kind = CMD_OFF;
                q_push = accept;
            end
            REQ_VOICE_DONE:
            begin
                q_data.kind = CMD_FIN;
                q_push = accept && (32'(req.voice_id) < NUM_VOICES);
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

### design/svalloc_cmd_fifo.sv
// Short command queue between the front end and the voice sequencer.
// Depends on svalloc_pkg.
module svalloc_cmd_fifo
    import svalloc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output cmd_t pop_data,
    output logic empty
);

    cmd_t               slot_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign full = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign empty = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### design/svalloc_back.sv
// Back end: voice table, held-note stack and the sequencer that runs commands.
// Depends on svalloc_pkg and svalloc_res_if; reads svalloc_cmd_fifo.
module svalloc_back
    import svalloc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic q_empty,
    input  cmd_t q_data,
    output logic q_pop,
    svalloc_res_if.source res
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COMPACT = 3'd1;
    localparam logic [2:0] S_REL = 3'd2;
    localparam logic [2:0] S_PICK = 3'd3;
    localparam logic [2:0] S_OLD = 3'd4;
    localparam logic [2:0] S_START = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [1:0]            kind_reg, kind_next;
    logic [6:0]            note_reg, note_next;
    logic [6:0]            vel_reg, vel_next;
    logic                  drop_first_reg, drop_first_next;
    logic                  rel_all_reg, rel_all_next;
    logic                  retrig_reg, retrig_next;

    logic [HCNT_W-1:0]     ri_reg, ri_next;
    logic [HCNT_W-1:0]     j_reg, j_next;
    logic [HCNT_W-1:0]     held_cnt_reg, held_cnt_next;
    logic                  rd_pend_reg, rd_pend_next;
    logic                  rd_first_reg, rd_first_next;
    logic [6:0]            rd_data_reg;
    logic [6:0]            top_reg, top_next;

    logic [VIDX_W-1:0]     scan_reg, scan_next;
    logic [VIDX_W-1:0]     pick_reg, pick_next;
    logic [31:0]           best_reg, best_next;
    logic                  stolen_reg, stolen_next;

    logic [NUM_VOICES-1:0] sounding_reg, sounding_next;
    logic [NUM_VOICES-1:0] gate_reg, gate_next;
    logic [6:0]            vnote_reg [NUM_VOICES];
    logic [6:0]            vnote_next [NUM_VOICES];
    logic [31:0]           vstamp_reg [NUM_VOICES];
    logic [31:0]           vstamp_next [NUM_VOICES];
    logic [31:0]           stamp_cnt_reg, stamp_cnt_next;
    logic                  last_valid_reg, last_valid_next;
    logic [6:0]            last_note_reg, last_note_next;

    logic                  out_valid_reg, out_valid_next;
    res_t                  out_reg, out_next;

    logic [6:0]            held_mem [HELD_DEPTH];
    logic                  mem_we;
    logic [HELD_AW-1:0]    mem_waddr;
    logic [6:0]            mem_wdata;
    logic                  rd_en;

    logic [NUM_VOICES-1:0] rel_mask, free_mask;
    logic [VIDX_W-1:0]     rel_idx, free_idx;
    logic                  rel_one;
    logic                  out_free;
    logic [31:0]           age;
    logic                  keep;
    logic                  glide_now;

    function automatic logic [VIDX_W-1:0] lowest_idx(input logic [NUM_VOICES-1:0] m);
        logic [VIDX_W-1:0] r;
        r = '0;
        for (int i = NUM_VOICES - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = VIDX_W'(i);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            rel_mask[v] = sounding_reg[v] && gate_reg[v]
                          && (rel_all_reg || (vnote_reg[v] == note_reg));
            free_mask[v] = !sounding_reg[v] || (vnote_reg[v] == note_reg);
        end
    end

    assign rel_idx = lowest_idx(rel_mask);
    assign free_idx = lowest_idx(free_mask);
    assign rel_one = ((rel_mask & (rel_mask - 1'b1)) == '0);
    assign out_free = !out_valid_reg || res.ready;
    assign age = stamp_cnt_reg - vstamp_reg[scan_reg];
    assign keep = drop_first_reg ? !rd_first_reg : (rd_data_reg != note_reg);
    assign glide_now = cfg.glide_enable && last_valid_reg && (last_note_reg != note_reg);
    assign rd_en = (state_reg == S_COMPACT) && (ri_reg < held_cnt_reg);

    always_comb
    begin
        state_next = state_reg;
        kind_next = kind_reg;
        note_next = note_reg;
        vel_next = vel_reg;
        drop_first_next = drop_first_reg;
        rel_all_next = rel_all_reg;
        retrig_next = retrig_reg;
        ri_next = ri_reg;
        j_next = j_reg;
        held_cnt_next = held_cnt_reg;
        rd_pend_next = 1'b0;
        rd_first_next = rd_first_reg;
        top_next = top_reg;
        scan_next = scan_reg;
        pick_next = pick_reg;
        best_next = best_reg;
        stolen_next = stolen_reg;
        sounding_next = sounding_reg;
        gate_next = gate_reg;
        vnote_next = vnote_reg;
        vstamp_next = vstamp_reg;
        stamp_cnt_next = stamp_cnt_reg;
        last_valid_next = last_valid_reg;
        last_note_next = last_note_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_next = out_reg;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wdata = note_reg;
        q_pop = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    kind_next = q_data.kind;
                    note_next = q_data.note;
                    vel_next = q_data.velocity;
                    ri_next = '0;
                    j_next = '0;
                    case (q_data.kind)
                        CMD_FIN:
                        begin
                            sounding_next[VIDX_W'(q_data.voice_id)] = 1'b0;
                            gate_next[VIDX_W'(q_data.voice_id)] = 1'b0;
                        end
                        CMD_ON:
                        begin
                            rel_all_next = 1'b1;
                            retrig_next = 1'b0;
                            if (cfg.mono_mode)
                            begin
                                if (held_cnt_reg == HCNT_W'(HELD_DEPTH))
                                begin
                                    drop_first_next = 1'b1;
                                    state_next = S_COMPACT;
                                end
                                else
                                begin
                                    mem_we = 1'b1;
                                    mem_waddr = held_cnt_reg[HELD_AW-1:0];
                                    mem_wdata = q_data.note;
                                    held_cnt_next = held_cnt_reg + 1'b1;
                                    state_next = S_REL;
                                end
                            end
                            else
                            begin
                                state_next = S_PICK;
                            end
                        end
                        CMD_OFF:
                        begin
                            rel_all_next = 1'b0;
                            retrig_next = 1'b0;
                            drop_first_next = 1'b0;
                            state_next = cfg.mono_mode ? S_COMPACT : S_REL;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_COMPACT:
            begin
                if (rd_en)
                begin
                    ri_next = ri_reg + 1'b1;
                    rd_pend_next = 1'b1;
                    rd_first_next = (ri_reg == '0);
                end
                if (rd_pend_reg)
                begin
                    if (keep)
                    begin
                        mem_we = 1'b1;
                        mem_waddr = j_reg[HELD_AW-1:0];
                        mem_wdata = rd_data_reg;
                        j_next = j_reg + 1'b1;
                        top_next = rd_data_reg;
                    end
                end
                else if (!rd_en)
                begin
                    state_next = S_REL;
                    if (kind_reg == CMD_ON)
                    begin
                        mem_we = 1'b1;
                        mem_waddr = j_reg[HELD_AW-1:0];
                        mem_wdata = note_reg;
                        held_cnt_next = j_reg + 1'b1;
                    end
                    else
                    begin
                        held_cnt_next = j_reg;
                        retrig_next = (j_reg != '0);
                    end
                end
            end

            S_REL:
            begin
                if (rel_mask != '0)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next = '0;
                        out_next.action = ACT_RELEASE;
                        out_next.voice_index = 3'(rel_idx);
                        out_next.last_of_run = !rel_all_reg && rel_one && !retrig_reg;
                        gate_next[rel_idx] = 1'b0;
                    end
                end
                else if (kind_reg == CMD_ON)
                begin
                    state_next = S_PICK;
                end
                else if (retrig_reg)
                begin
                    kind_next = CMD_ON;
                    note_next = top_reg;
                    vel_next = RETRIG_VELOCITY;
                    rel_all_next = 1'b1;
                    retrig_next = 1'b0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_PICK:
            begin
                if (free_mask != '0)
                begin
                    pick_next = free_idx;
                    stolen_next = 1'b0;
                    state_next = S_START;
                end
                else
                begin
                    scan_next = '0;
                    best_next = '0;
                    state_next = S_OLD;
                end
            end

            S_OLD:
            begin
                if ((scan_reg == '0) || (age > best_reg))
                begin
                    best_next = age;
                    pick_next = scan_reg;
                end
                if (scan_reg == VIDX_W'(NUM_VOICES - 1))
                begin
                    stolen_next = 1'b1;
                    state_next = S_START;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_START:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.action = ACT_START;
                    out_next.voice_index = 3'(pick_reg);
                    out_next.start_note = note_reg;
                    out_next.start_velocity = vel_reg;
                    out_next.was_stolen = stolen_reg;
                    out_next.glide = glide_now;
                    out_next.glide_from_note = glide_now ? last_note_reg : note_reg;
                    out_next.last_of_run = 1'b1;
                    sounding_next[pick_reg] = 1'b1;
                    gate_next[pick_reg] = 1'b1;
                    vnote_next[pick_reg] = note_reg;
                    vstamp_next[pick_reg] = stamp_cnt_reg;
                    stamp_cnt_next = stamp_cnt_reg + 1'b1;
                    last_valid_next = 1'b1;
                    last_note_next = note_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg <= CMD_ON;
            note_reg <= '0;
            vel_reg <= '0;
            drop_first_reg <= 1'b0;
            rel_all_reg <= 1'b0;
            retrig_reg <= 1'b0;
            ri_reg <= '0;
            j_reg <= '0;
            held_cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
            rd_first_reg <= 1'b0;
            top_reg <= '0;
            scan_reg <= '0;
            pick_reg <= '0;
            best_reg <= '0;
            stolen_reg <= 1'b0;
            sounding_reg <= '0;
            gate_reg <= '0;
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                vnote_reg[v] <= '0;
                vstamp_reg[v] <= '0;
            end
            stamp_cnt_reg <= '0;
            last_valid_reg <= 1'b0;
            last_note_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg <= kind_next;
            note_reg <= note_next;
            vel_reg <= vel_next;
            drop_first_reg <= drop_first_next;
            rel_all_reg <= rel_all_next;
            retrig_reg <= retrig_next;
            ri_reg <= ri_next;
            j_reg <= j_next;
            held_cnt_reg <= held_cnt_next;
            rd_pend_reg <= rd_pend_next;
            rd_first_reg <= rd_first_next;
            top_reg <= top_next;
            scan_reg <= scan_next;
            pick_reg <= pick_next;
            best_reg <= best_next;
            stolen_reg <= stolen_next;
            sounding_reg <= sounding_next;
            gate_reg <= gate_next;
            vnote_reg <= vnote_next;
            vstamp_reg <= vstamp_next;
            stamp_cnt_reg <= stamp_cnt_next;
            last_valid_reg <= last_valid_next;
            last_note_reg <= last_note_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // held-note stack: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            held_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= held_mem[ri_reg[HELD_AW-1:0]];
        end
    end

    assign res.valid = out_valid_reg;
    assign res.action = out_reg.action;
    assign res.voice_index = out_reg.voice_index;
    assign res.start_note = out_reg.start_note;
    assign res.start_velocity = out_reg.start_velocity;
    assign res.was_stolen = out_reg.was_stolen;
    assign res.glide = out_reg.glide;
    assign res.glide_from_note = out_reg.glide_from_note;
    assign res.last_of_run = out_reg.last_of_run;

endmodule

### tb/synth_voice_allocator_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the voice allocator: watches the request, result and register ports,
// predicts each run of results and compares them in order. Depends on svalloc_pkg, svalloc_if.
module synth_voice_allocator_checker
    import svalloc_pkg::*;
#(
    parameter logic [2:0] MONO_ADDR = 3'd0,
    parameter logic [2:0] GLIDE_ADDR = 3'd4
)
(
    input  logic        clk,
    input  logic        rst_n,
    svalloc_req_if      req,
    svalloc_res_if      res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          outstanding
);

    logic                  mono_on;
    logic                  glide_on;
    logic [NUM_VOICES-1:0] sounding;
    logic [NUM_VOICES-1:0] gated;
    logic [6:0]            voice_note [NUM_VOICES];
    logic [31:0]           voice_stamp [NUM_VOICES];
    logic [31:0]           stamp_ctr;
    logic [6:0]            held [HELD_DEPTH];
    int                    held_cnt;
    logic [7:0]            prev_note;
    res_t                  run_q [$];
    res_t                  expected_q [$];
    res_t                  want;

    initial mismatches = 0;

    function automatic void add_release(int v);
        res_t r;
        r = '0;
        r.action = ACT_RELEASE;
        r.voice_index = 3'(v);
        gated[v] = 1'b0;
        run_q = {run_q, r};
    endfunction

    function automatic void start_voice(logic [6:0] n, logic [6:0] vel, bit push);
        res_t        r;
        int          pick;
        int          oldest;
        logic [31:0] age;
        logic [31:0] best_age;
        pick = -1;
        oldest = 0;
        best_age = '0;
        if (mono_on)
        begin
            if (push)
            begin
                // full stack: drop the oldest entry
                if (held_cnt >= HELD_DEPTH)
                begin
                    for (int i = 0; i < HELD_DEPTH - 1; i++)
                        held[i] = held[i + 1];
                    held_cnt = HELD_DEPTH - 1;
                end
                held[held_cnt] = n;
                held_cnt++;
            end
            for (int v = 0; v < NUM_VOICES; v++)
                if (sounding[v] && gated[v])
                    add_release(v);
        end
        for (int v = 0; v < NUM_VOICES; v++)
        begin
            if (!sounding[v] || voice_note[v] == n)
            begin
                pick = v;
                break;
            end
            age = stamp_ctr - voice_stamp[v];
            if (v == 0 || age > best_age)
            begin
                best_age = age;
                oldest = v;
            end
        end
        r = '0;
        r.was_stolen = (pick < 0);
        if (pick < 0)
            pick = oldest;
        sounding[pick] = 1'b1;
        gated[pick] = 1'b1;
        voice_note[pick] = n;
        voice_stamp[pick] = stamp_ctr;
        stamp_ctr++;
        r.action = ACT_START;
        r.voice_index = 3'(pick);
        r.start_note = n;
        r.start_velocity = vel;
        r.glide = glide_on && !prev_note[7] && prev_note[6:0] != n;
        r.glide_from_note = r.glide ? prev_note[6:0] : n;
        prev_note = {1'b0, n};
        run_q = {run_q, r};
    endfunction

    function automatic void end_note(logic [6:0] n);
        int kept;
        kept = 0;
        for (int v = 0; v < NUM_VOICES; v++)
            if (sounding[v] && gated[v] && voice_note[v] == n)
                add_release(v);
        if (mono_on)
        begin
            for (int i = 0; i < held_cnt; i++)
                if (held[i] != n)
                begin
                    held[kept] = held[i];
                    kept++;
                end
            held_cnt = kept;
            // retrigger the newest held note, no push
            if (kept > 0)
                start_voice(held[kept - 1], RETRIG_VELOCITY, 1'b0);
        end
    endfunction

    function automatic void predict_request(logic [1:0] kind, logic [6:0] n,
                                            logic [6:0] vel, logic [2:0] vid);
        run_q.delete();
        case (kind)
            REQ_NOTE_ON:  start_voice(n, vel, 1'b1);
            REQ_NOTE_OFF: end_note(n);
            REQ_VOICE_DONE:
                if (int'(vid) < NUM_VOICES)
                begin
                    sounding[vid] = 1'b0;
                    gated[vid] = 1'b0;
                end
            default: ;
        endcase
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last_of_run = 1'b1;
        expected_q = {expected_q, run_q};
    endfunction

    task automatic report(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check(string name, int got, int exp_val);
        if (got != exp_val)
            report($sformatf("%s got %0d, expected %0d", name, got, exp_val));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mono_on = 1'b0;
            glide_on = 1'b0;
            sounding = '0;
            gated = '0;
            for (int v = 0; v < NUM_VOICES; v++)
            begin
                voice_note[v] = '0;
                voice_stamp[v] = '0;
            end
            stamp_ctr = '0;
            held_cnt = 0;
            prev_note = 8'hFF;
            expected_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == MONO_ADDR)
                    mono_on = pwdata[0];
                else if (paddr == GLIDE_ADDR)
                    glide_on = pwdata[0];
            end
            if (req.valid && req.ready)
                predict_request(req.req_type, req.note, req.velocity, req.voice_id);
            if (res.valid && res.ready)
            begin
                if (expected_q.size() == 0)
                    report($sformatf("result transfer with none expected, voice %0d action %0d",
                                     res.voice_index, res.action));
                else
                begin
                    want = expected_q.pop_front();
                    check("action", res.action, want.action);
                    check("voice_index", res.voice_index, want.voice_index);
                    check("start_note", res.start_note, want.start_note);
                    check("start_velocity", res.start_velocity, want.start_velocity);
                    check("was_stolen", res.was_stolen, want.was_stolen);
                    check("glide", res.glide, want.glide);
                    check("glide_from_note", res.glide_from_note, want.glide_from_note);
                    check("last_of_run", res.last_of_run, want.last_of_run);
                end
            end
            outstanding = expected_q.size();
        end
    end

endmodule

### tb/synth_voice_allocator_tb.sv
`timescale 1ns / 1ps
// Top of the voice allocator testbench: clock, reset, register writes and request traffic.
// Depends on svalloc_pkg, svalloc_if, synth_voice_allocator and synth_voice_allocator_checker.
module synth_voice_allocator_tb;
    import svalloc_pkg::*;

    localparam logic [2:0] REG_MONO_MODE = 3'd0;
    localparam logic [2:0] REG_GLIDE_ENABLE = 3'd4;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES = 200;
    localparam int IDLE_PCT = 35;
    localparam int PHASE_ITEMS = 94;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          mismatches;
    int          outstanding;
    int          cycles = 0;
    bit          send_idle;
    bit          recv_idle;
    int          holds_asked = 0;
    int          holds_done = 0;
    logic [6:0]  pool_base;

    svalloc_req_if req_ch ();
    svalloc_res_if res_ch ();

    synth_voice_allocator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    synth_voice_allocator_checker #(
        .MONO_ADDR  (REG_MONO_MODE),
        .GLIDE_ADDR (REG_GLIDE_ENABLE)
    ) alloc_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .res         (res_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, plus long hold-offs on request
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done < holds_asked)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
                res_ch.ready <= !(recv_idle && $urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic send_req(logic [1:0] kind, logic [6:0] n, logic [6:0] vel, logic [2:0] vid);
        while (send_idle && $urandom_range(99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.note <= n;
        req_ch.velocity <= vel;
        req_ch.voice_id <= vid;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= {31'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic quiesce();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        // voice-finished requests give no result; let the block settle
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(logic mono, logic glide);
        quiesce();
        write_reg(REG_MONO_MODE, mono);
        write_reg(REG_GLIDE_ENABLE, glide);
    endtask

    task automatic random_phase(int count);
        int         done;
        int         pick;
        logic [1:0] kind;
        logic [6:0] n;
        done = 0;
        pool_base = 7'($urandom_range(116));
        while (done < count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                kind = REQ_NOTE_ON;
            else if (pick < 85)
                kind = REQ_NOTE_OFF;
            else if (pick < 96)
                kind = REQ_VOICE_DONE;
            else
                kind = REQ_UNKNOWN;
            // mostly a narrow note pool so offs hit held notes
            if ($urandom_range(3) == 0)
                n = 7'($urandom_range(127));
            else
                n = pool_base + 7'($urandom_range(11));
            send_req(kind, n, 7'($urandom_range(127)), 3'($urandom_range(7)));
            if (kind != REQ_UNKNOWN)
                done++;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_NOTE_ON;
        req_ch.note = '0;
        req_ch.velocity = '0;
        req_ch.voice_id = '0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // polyphonic: extremes, same-note reuse, fill and steal, release once
        set_mode(1'b0, 1'b0);
        send_req(REQ_NOTE_ON, 7'd0, 7'd0, 3'd0);
        send_req(REQ_NOTE_ON, 7'd127, 7'd127, 3'd7);
        send_req(REQ_NOTE_ON, 7'd127, 7'd64, 3'd0);
        for (int k = 0; k < 6; k++)
            send_req(REQ_NOTE_ON, 7'(60 + k), 7'd100, 3'd0);
        send_req(REQ_NOTE_ON, 7'd72, 7'd90, 3'd0);
        send_req(REQ_NOTE_OFF, 7'd127, 7'd0, 3'd0);
        send_req(REQ_NOTE_OFF, 7'd127, 7'd0, 3'd0);
        send_req(REQ_VOICE_DONE, 7'd0, 7'd0, 3'd1);
        send_req(REQ_VOICE_DONE, 7'd0, 7'd0, 3'd7);
        send_req(REQ_UNKNOWN, 7'd127, 7'd127, 3'd7);
        send_req(REQ_NOTE_OFF, 7'd5, 7'd0, 3'd0);

        // mono with glide: retrigger after note off, empty stack
        set_mode(1'b1, 1'b1);
        send_req(REQ_NOTE_ON, 7'd40, 7'd80, 3'd0);
        send_req(REQ_NOTE_ON, 7'd45, 7'd70, 3'd0);
        send_req(REQ_NOTE_ON, 7'd45, 7'd60, 3'd0);
        send_req(REQ_NOTE_OFF, 7'd45, 7'd0, 3'd0);
        send_req(REQ_NOTE_OFF, 7'd40, 7'd0, 3'd0);

        set_mode(1'b0, 1'b1);
        random_phase(PHASE_ITEMS);

        set_mode(1'b1, 1'b0);
        random_phase(PHASE_ITEMS / 2);
        holds_asked++;
        random_phase(PHASE_ITEMS - PHASE_ITEMS / 2);

        set_mode(1'b1, 1'b1);
        send_idle = 1'b0;
        recv_idle = 1'b0;
        random_phase(60);
        send_idle = 1'b1;
        recv_idle = 1'b1;
        random_phase(PHASE_ITEMS - 60);

        // held stack survives the switch back and forth
        set_mode(1'b0, 1'b0);
        random_phase(PHASE_ITEMS);

        set_mode(1'b1, 1'b1);
        random_phase(PHASE_ITEMS);

        quiesce();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
